// ----- rtl/lbrs_pkg.sv -----
`timescale 1ns / 1ps

package lbrs_pkg;

    localparam int MAX_KEYS = 1024;
    localparam int ADDR_W   = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int KEY_W    = 64;
    localparam int DIGIT_W  = 8;
    localparam int RADIX    = 256;
    localparam int BIN_W    = $clog2(RADIX);
    localparam int BINC_W   = BIN_W + 1;
    localparam int PASSES   = KEY_W / DIGIT_W;
    localparam int PASS_W   = $clog2(PASSES);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key_in;
        logic             last_in;
    } lbrs_cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic             last_out;
        status_t          status;
    } lbrs_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CLEAR,
        ST_CNT_RD,
        ST_CNT_LOOK,
        ST_CNT_UPD,
        ST_PFX,
        ST_SCT_RD,
        ST_SCT_LOOK,
        ST_SCT_WR
    } lbrs_state_t;

endpackage

// ----- rtl/lsd_byte_radix_sorter_core.sv -----
`timescale 1ns / 1ps
// Load: result in the cycle after start; loads can be issued every cycle until one is flagged last.
// Fetch: result registered out of state ST_FETCH, during which busy is high; then back to idle.
// A load flagged last keeps busy high while the keys sort byte by byte, lowest first,
// using one shared adder and a read-modify-write per key on a 256-entry count memory.
// The receiver cannot stall; done strobes each result for one cycle.
// Reset (rst_n low, asynchronous) empties the set and returns to idle; stores are not cleared.

module lsd_byte_radix_sorter_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lbrs_pkg::lbrs_cmd_t cmd,
    output logic               done,
    output lbrs_pkg::lbrs_rsp_t rsp
);

    import lbrs_pkg::*;

    lbrs_state_t        state_reg, state_next;
    logic [PASS_W-1:0]  pass_reg, pass_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [BINC_W-1:0]  bin_reg, bin_next;
    logic [CNT_W-1:0]   sum_reg, sum_next;
    logic [BIN_W-1:0]   digit_reg, digit_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   item_count_reg, item_count_next;
    logic [CNT_W-1:0]   fetch_index_reg, fetch_index_next;
    logic               sorted_ready_reg, sorted_ready_next;
    logic               fetch_ok_reg, fetch_ok_next;
    logic               fetch_last_reg, fetch_last_next;
    logic               done_reg, done_next;
    lbrs_rsp_t          rsp_reg, rsp_next;

    logic               a_we, b_we, c_we;
    logic [ADDR_W-1:0]  a_waddr, b_waddr, a_raddr, b_raddr;
    logic [KEY_W-1:0]   a_wdata, b_wdata, a_rdata, b_rdata;
    logic [BIN_W-1:0]   c_waddr, c_raddr;
    logic [CNT_W-1:0]   c_wdata, c_rdata;

    logic               dst_we;
    logic [ADDR_W-1:0]  dst_waddr, src_raddr;
    logic [KEY_W-1:0]   src_rdata;
    logic [BIN_W-1:0]   src_digit;
    logic [CNT_W-1:0]   eff_count;

    logic [CNT_W-1:0]   alu_a, alu_b, alu_sum;

    lbrs_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_store_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    lbrs_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_store_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    lbrs_ram #(.WIDTH(CNT_W), .DEPTH(RADIX)) u_counts (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    assign alu_sum   = alu_a + alu_b;
    assign src_rdata = pass_reg[0] ? b_rdata : a_rdata;
    assign src_digit = src_rdata[DIGIT_W*pass_reg +: DIGIT_W];
    assign eff_count = sorted_ready_reg ? '0 : item_count_reg;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pass_reg         <= '0;
            idx_reg          <= '0;
            bin_reg          <= '0;
            item_count_reg   <= '0;
            fetch_index_reg  <= '0;
            sorted_ready_reg <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pass_reg         <= pass_next;
            idx_reg          <= idx_next;
            bin_reg          <= bin_next;
            item_count_reg   <= item_count_next;
            fetch_index_reg  <= fetch_index_next;
            sorted_ready_reg <= sorted_ready_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        digit_reg      <= digit_next;
        key_reg        <= key_next;
        fetch_ok_reg   <= fetch_ok_next;
        fetch_last_reg <= fetch_last_next;
        rsp_reg        <= rsp_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        pass_next         = pass_reg;
        idx_next          = idx_reg;
        bin_next          = bin_reg;
        sum_next          = sum_reg;
        digit_next        = digit_reg;
        key_next          = key_reg;
        item_count_next   = item_count_reg;
        fetch_index_next  = fetch_index_reg;
        sorted_ready_next = sorted_ready_reg;
        fetch_ok_next     = fetch_ok_reg;
        fetch_last_next   = fetch_last_reg;
        done_next         = 1'b0;
        rsp_next          = rsp_reg;

        alu_a     = '0;
        alu_b     = '0;
        a_we      = 1'b0;
        a_waddr   = '0;
        a_wdata   = cmd.key_in;
        a_raddr   = '0;
        dst_we    = 1'b0;
        dst_waddr = alu_sum[ADDR_W-1:0];
        src_raddr = idx_reg[ADDR_W-1:0];
        c_we      = 1'b0;
        c_waddr   = digit_reg;
        c_wdata   = alu_sum;
        c_raddr   = src_digit;

        case (state_reg)
            ST_IDLE:
            begin
                a_raddr = fetch_index_reg[ADDR_W-1:0];
                if (start)
                begin
                    if (cmd.req_type == REQ_LOAD)
                    begin
                        sorted_ready_next = 1'b0;
                        fetch_index_next  = '0;
                        done_next         = 1'b1;
                        rsp_next.key_out  = '0;
                        rsp_next.last_out = 1'b0;
                        if (eff_count < CNT_W'(MAX_KEYS))
                        begin
                            a_we            = 1'b1;
                            a_waddr         = eff_count[ADDR_W-1:0];
                            item_count_next = eff_count + CNT_W'(1);
                            rsp_next.status = STATUS_OK;
                        end
                        else
                        begin
                            item_count_next = eff_count;
                            rsp_next.status = STATUS_FULL;
                        end
                        if (cmd.last_in)
                        begin
                            pass_next  = '0;
                            bin_next   = '0;
                            state_next = ST_CLEAR;
                        end
                    end
                    else
                    begin
                        fetch_ok_next   = sorted_ready_reg &&
                                          (fetch_index_reg < item_count_reg);
                        fetch_last_next = (fetch_index_reg + CNT_W'(1)) == item_count_reg;
                        if (sorted_ready_reg && (fetch_index_reg < item_count_reg))
                        begin
                            fetch_index_next = fetch_index_reg + CNT_W'(1);
                        end
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_FETCH:
            begin
                done_next = 1'b1;
                if (fetch_ok_reg)
                begin
                    rsp_next.key_out  = a_rdata;
                    rsp_next.last_out = fetch_last_reg;
                    rsp_next.status   = STATUS_OK;
                end
                else
                begin
                    rsp_next.key_out  = '0;
                    rsp_next.last_out = 1'b0;
                    rsp_next.status   = STATUS_EMPTY;
                end
                state_next = ST_IDLE;
            end

            ST_CLEAR:
            begin
                c_we    = 1'b1;
                c_waddr = bin_reg[BIN_W-1:0];
                c_wdata = '0;
                if (bin_reg == BINC_W'(RADIX - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_CNT_RD;
                end
                else
                begin
                    bin_next = bin_reg + BINC_W'(1);
                end
            end

            ST_CNT_RD:
            begin
                state_next = ST_CNT_LOOK;
            end

            ST_CNT_LOOK:
            begin
                digit_next = src_digit;
                state_next = ST_CNT_UPD;
            end

            ST_CNT_UPD:
            begin
                alu_a = c_rdata;
                alu_b = CNT_W'(1);
                c_we  = 1'b1;
                if ((idx_reg + CNT_W'(1)) == item_count_reg)
                begin
                    bin_next   = '0;
                    sum_next   = '0;
                    state_next = ST_PFX;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_CNT_RD;
                end
            end

            ST_PFX:
            begin
                alu_a   = sum_reg;
                alu_b   = c_rdata;
                c_raddr = bin_reg[BIN_W-1:0];
                c_waddr = BIN_W'(bin_reg - BINC_W'(1));
                if (bin_reg != '0)
                begin
                    c_we     = 1'b1;
                    sum_next = alu_sum;
                end
                if (bin_reg == BINC_W'(RADIX))
                begin
                    idx_next   = item_count_reg - CNT_W'(1);
                    state_next = ST_SCT_RD;
                end
                else
                begin
                    bin_next = bin_reg + BINC_W'(1);
                end
            end

            ST_SCT_RD:
            begin
                state_next = ST_SCT_LOOK;
            end

            ST_SCT_LOOK:
            begin
                digit_next = src_digit;
                key_next   = src_rdata;
                state_next = ST_SCT_WR;
            end

            ST_SCT_WR:
            begin
                alu_a  = c_rdata;
                alu_b  = '1;
                c_we   = 1'b1;
                dst_we = 1'b1;
                if (idx_reg == '0)
                begin
                    if (pass_reg == PASS_W'(PASSES - 1))
                    begin
                        sorted_ready_next = 1'b1;
                        fetch_index_next  = '0;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        pass_next  = pass_reg + PASS_W'(1);
                        bin_next   = '0;
                        state_next = ST_CLEAR;
                    end
                end
                else
                begin
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = ST_SCT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg != ST_IDLE && state_reg != ST_FETCH)
        begin
            a_raddr = src_raddr;
            if (pass_reg[0])
            begin
                a_we    = dst_we;
                a_waddr = dst_waddr;
                a_wdata = key_reg;
            end
        end
    end

    // route source reads and destination writes by pass parity
    always_comb
    begin
        b_we    = 1'b0;
        b_waddr = dst_waddr;
        b_wdata = key_reg;
        b_raddr = src_raddr;
        if (state_reg != ST_IDLE && state_reg != ST_FETCH && !pass_reg[0])
        begin
            b_we = dst_we;
        end
    end

endmodule

// ----- rtl/lbrs_ram.sv -----
`timescale 1ns / 1ps

module lbrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lbrs_checker.sv -----
`timescale 1ns / 1ps

module lbrs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input lbrs_pkg::lbrs_cmd_t cmd,
    input logic                done,
    input lbrs_pkg::lbrs_rsp_t rsp
);

    import lbrs_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.req_type == REQ_LOAD) |=> done)
    else $error("load transaction without result on next cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.req_type == REQ_FETCH) |-> ##2 done)
    else $error("fetch transaction without result two cycles later");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.req_type == REQ_LOAD && cmd.last_in) |=> busy)
    else $error("last load did not start the sort");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == STATUS_OK || rsp.status == STATUS_FULL ||
                  rsp.status == STATUS_EMPTY))
    else $error("undefined status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STATUS_OK) |-> (rsp.key_out == '0 && !rsp.last_out))
    else $error("error result carries a key");

endmodule

bind lsd_byte_radix_sorter_core lbrs_checker u_lbrs_checker (.*);
